// ----- sv/lfu_pkg.sv -----
// Shared constants and types for the LFU victim selector.
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int NUM_LINES  = 64;
  localparam int COUNT_BITS = 16;

  localparam int IDX_W   = $clog2(NUM_LINES);
  localparam int RANGE_W = IDX_W + 1;
  localparam int FIELD_W = 6;
  localparam int REG_W   = 7;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_PER_SET = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd2;

  localparam logic FUNC_TOUCH  = 1'b0;
  localparam logic FUNC_VICTIM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TOUCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

endpackage

// ----- sv/lfu_victim_selector.sv -----
// LFU replacement: per-line use counters and a serial least-count victim scan.
//
// Channel  Dir  Signals                                         Handshake
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i                write when cfg_we_i
// cmd      in   start, func_i, line_index_i, set_index_i        start && !busy
// result   out  result_valid_o, victim_line_o                   one-cycle strobe
//
// A touch is a counter read, then a write back of count + 1, saturating at CNT_MAX.
// A victim request scans N lines (up to NUM_LINES), one counter read per cycle
// from the single RAM read port; the word is on the outputs in the first cycle
// with busy low. Reset zeroes all counters through valid bits.
// Results cannot be stalled; busy is high while an item is in work.
`timescale 1ns / 1ps

module lfu_victim_selector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lfu_pkg::REG_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func_i,
  input  logic [lfu_pkg::FIELD_W-1:0]   line_index_i,
  input  logic [lfu_pkg::FIELD_W-1:0]   set_index_i,
  output logic                          result_valid_o,
  output logic [lfu_pkg::FIELD_W-1:0]   victim_line_o
);

  localparam int IdxW   = lfu_pkg::IDX_W;
  localparam int RangeW = lfu_pkg::RANGE_W;
  localparam int CntW   = lfu_pkg::COUNT_BITS;
  localparam int LoW    = lfu_pkg::FIELD_W + lfu_pkg::REG_W;

  lfu_pkg::state_e state_q, state_d;

  logic [lfu_pkg::MODE_W-1:0] assoc_mode_q;
  logic [lfu_pkg::REG_W-1:0]  lines_in_use_q, ways_per_set_q;

  logic [lfu_pkg::NUM_LINES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]   line_q, line_d;
  logic [RangeW-1:0] k_q, k_d, hi_q, hi_d;
  logic              cmp_pend_q, cmp_pend_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [CntW-1:0]   best_v_q, best_v_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic              res_vld_q, res_vld_d;
  logic [IdxW-1:0]   res_idx_q, res_idx_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [CntW-1:0] ram_wdata, ram_rdata;

  logic                      accept;
  logic [lfu_pkg::REG_W-1:0] ways_eff;
  logic [LoW-1:0]            lo_full;
  logic [LoW:0]              hi_sum;
  logic [RangeW-1:0]         hi_full, hi_set;
  logic [CntW-1:0]           touch_cnt, scan_cnt;

  lfu_ram #(
    .Width(CntW),
    .Depth(lfu_pkg::NUM_LINES)
  ) u_counts (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy           = (state_q != lfu_pkg::ST_IDLE);
  assign accept         = start && !busy;
  assign result_valid_o = res_vld_q;
  assign victim_line_o  = lfu_pkg::FIELD_W'(res_idx_q);

  // range of the scan
  assign ways_eff = (ways_per_set_q == '0) ? lfu_pkg::REG_W'(1) : ways_per_set_q;
  assign lo_full  = LoW'(set_index_i) * LoW'(ways_eff);
  assign hi_sum   = (LoW + 1)'(lo_full) + (LoW + 1)'(ways_eff);
  assign hi_set   = (hi_sum > (LoW + 1)'(lfu_pkg::NUM_LINES)) ?
                    RangeW'(lfu_pkg::NUM_LINES) : RangeW'(hi_sum);
  always_comb begin
    if (lines_in_use_q == '0) begin
      hi_full = RangeW'(1);
    end else if ((RangeW + lfu_pkg::REG_W)'(lines_in_use_q) >
                 (RangeW + lfu_pkg::REG_W)'(lfu_pkg::NUM_LINES)) begin
      hi_full = RangeW'(lfu_pkg::NUM_LINES);
    end else begin
      hi_full = RangeW'(lines_in_use_q);
    end
  end

  assign touch_cnt = valid_q[line_q] ? ram_rdata : '0;
  assign scan_cnt  = valid_q[cmp_idx_q] ? ram_rdata : '0;

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    line_d     = line_q;
    k_d        = k_q;
    hi_d       = hi_q;
    cmp_pend_d = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    best_v_d   = best_v_q;
    best_idx_d = best_idx_q;
    res_vld_d  = 1'b0;
    res_idx_d  = res_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = line_q;
    ram_wdata  = touch_cnt + CntW'(1);
    ram_raddr  = k_q[IdxW-1:0];

    // compare stage, one word behind the read
    if (cmp_pend_q && (scan_cnt <= best_v_q)) begin
      best_v_d   = scan_cnt;
      best_idx_d = cmp_idx_q;
    end

    unique case (state_q)
      lfu_pkg::ST_IDLE: begin
        ram_raddr = IdxW'(line_index_i);
        if (accept && (assoc_mode_q == lfu_pkg::MODE_FULL ||
                       assoc_mode_q == lfu_pkg::MODE_SET)) begin
          if (func_i == lfu_pkg::FUNC_TOUCH) begin
            line_d  = IdxW'(line_index_i);
            state_d = lfu_pkg::ST_TOUCH;
          end else begin
            best_v_d = lfu_pkg::CNT_MAX;
            if (assoc_mode_q == lfu_pkg::MODE_FULL) begin
              k_d     = '0;
              hi_d    = hi_full;
              state_d = lfu_pkg::ST_SCAN;
            end else if (lo_full < LoW'(lfu_pkg::NUM_LINES)) begin
              k_d     = RangeW'(lo_full);
              hi_d    = hi_set;
              state_d = lfu_pkg::ST_SCAN;
            end
          end
        end
      end
      lfu_pkg::ST_TOUCH: begin
        if (touch_cnt != lfu_pkg::CNT_MAX) begin
          ram_we = 1'b1;
        end
        valid_d[line_q] = 1'b1;
        state_d         = lfu_pkg::ST_IDLE;
      end
      lfu_pkg::ST_SCAN: begin
        cmp_pend_d = 1'b1;
        cmp_idx_d  = k_q[IdxW-1:0];
        k_d        = k_q + RangeW'(1);
        if (k_d == hi_q) begin
          state_d = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN: begin
        res_vld_d = 1'b1;
        res_idx_d = best_idx_d;
        state_d   = lfu_pkg::ST_IDLE;
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= lfu_pkg::ST_IDLE;
      valid_q        <= '0;
      cmp_pend_q     <= 1'b0;
      res_vld_q      <= 1'b0;
      assoc_mode_q   <= '0;
      lines_in_use_q <= lfu_pkg::REG_W'(64);
      ways_per_set_q <= lfu_pkg::REG_W'(4);
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      cmp_pend_q <= cmp_pend_d;
      res_vld_q  <= res_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lfu_pkg::CFG_ASSOC_MODE:   assoc_mode_q   <= cfg_wdata_i[lfu_pkg::MODE_W-1:0];
          lfu_pkg::CFG_LINES_IN_USE: lines_in_use_q <= cfg_wdata_i;
          lfu_pkg::CFG_WAYS_PER_SET: ways_per_set_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    line_q     <= line_d;
    k_q        <= k_d;
    hi_q       <= hi_d;
    cmp_idx_q  <= cmp_idx_d;
    best_v_q   <= best_v_d;
    best_idx_q <= best_idx_d;
    res_idx_q  <= res_idx_d;
  end

endmodule

// ----- sv/lfu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
